// File: sv/rbc_pkg.sv
// shared constants and types for the reorder buffer commit block
package rbc_pkg;

    localparam int KIND_W = 2;
    localparam int DEST_W = 5;
    localparam int DATA_W = 32;
    localparam int TAG_W  = 4;

    localparam logic [KIND_W-1:0] KIND_BRANCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT   = 2'd2;

    localparam logic [DATA_W-1:0] BRANCH_STEP = 32'd4;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] alt_pc;
    } t_head_entry;

    typedef struct packed {
        logic              taken;
        logic              mispredict;
        logic              exit_req;
        logic [DATA_W-1:0] branch_pc;
        logic [DATA_W-1:0] redirect_pc;
    } t_commit_res;

endpackage

// File: sv/reorder_buffer_commit.sv
// reorder buffer with in-order commit, branch check and flush
//
// Usage: each input request is one processor cycle of the buffer: an optional
// allocation at the tail plus optional ALU and memory writebacks. Each request
// gives exactly one result: the allocation outcome and the head commit.
// Input channel: i_in_valid / o_in_stall; output channel: o_out_valid /
// i_out_stall. A request is taken when valid is high and stall is low.
// A request loads the input register when it is accepted; one pass of
// commit/allocate logic then loads the result register once the output side is
// free. Throughput: one request per cycle while the receiver does not stall;
// the buffer state is updated in the same cycle the result register loads, so
// the next request sees it.
// A mispredicted branch commit makes the following request a flush: all
// entries are dropped, its allocation and writebacks are discarded, and its
// result is all zero.
// Reset (synchronous, active low) empties the buffer and both registers.
// When the receiver stalls, the result holds; the input register still takes
// one more request, after which o_in_stall rises until the result moves on.
module reorder_buffer_commit #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_alloc_valid,
    input  logic [rbc_pkg::KIND_W-1:0] i_alloc_kind,
    input  logic [rbc_pkg::DEST_W-1:0] i_alloc_dest,
    input  logic [rbc_pkg::DATA_W-1:0] i_alloc_pc,
    input  logic [rbc_pkg::DATA_W-1:0] i_alloc_alt_pc,
    input  logic                    i_alu_valid,
    input  logic [rbc_pkg::TAG_W-1:0]  i_alu_tag,
    input  logic [rbc_pkg::DATA_W-1:0] i_alu_value,
    input  logic                    i_mem_valid,
    input  logic [rbc_pkg::TAG_W-1:0]  i_mem_tag,
    input  logic [rbc_pkg::DATA_W-1:0] i_mem_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [rbc_pkg::TAG_W-1:0]  o_alloc_index,
    output logic                    o_alloc_accepted,
    output logic                    o_commit_valid,
    output logic [rbc_pkg::KIND_W-1:0] o_commit_kind,
    output logic [rbc_pkg::DEST_W-1:0] o_commit_dest,
    output logic [rbc_pkg::DATA_W-1:0] o_commit_value,
    output logic [rbc_pkg::TAG_W-1:0]  o_commit_index,
    output logic [rbc_pkg::DATA_W-1:0] o_branch_pc,
    output logic                    o_branch_taken,
    output logic                    o_mispredict,
    output logic [rbc_pkg::DATA_W-1:0] o_redirect_pc,
    output logic                    o_exit_request
);
    import rbc_pkg::*;

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    // input register
    logic              r_s1_valid;
    logic              r_s1_alloc_valid;
    logic [KIND_W-1:0] r_s1_alloc_kind;
    logic [DEST_W-1:0] r_s1_alloc_dest;
    logic [DATA_W-1:0] r_s1_alloc_pc;
    logic [DATA_W-1:0] r_s1_alloc_alt_pc;
    logic              r_s1_alu_valid;
    logic [TAG_W-1:0]  r_s1_alu_tag;
    logic [DATA_W-1:0] r_s1_alu_value;
    logic              r_s1_mem_valid;
    logic [TAG_W-1:0]  r_s1_mem_tag;
    logic [DATA_W-1:0] r_s1_mem_value;

    // buffer state
    logic [KIND_W-1:0] r_kind   [BUFFER_DEPTH];
    logic [DEST_W-1:0] r_dest   [BUFFER_DEPTH];
    logic [DATA_W-1:0] r_value  [BUFFER_DEPTH];
    logic [DATA_W-1:0] r_pc     [BUFFER_DEPTH];
    logic [DATA_W-1:0] r_alt_pc [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] r_done, n_done;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic              r_flush, n_flush;

    // result register
    logic              r_out_valid;
    logic [TAG_W-1:0]  r_out_alloc_index, n_out_alloc_index;
    logic              r_out_alloc_accepted, n_out_alloc_accepted;
    logic              r_out_commit_valid, n_out_commit_valid;
    logic [KIND_W-1:0] r_out_commit_kind, n_out_commit_kind;
    logic [DEST_W-1:0] r_out_commit_dest, n_out_commit_dest;
    logic [DATA_W-1:0] r_out_commit_value, n_out_commit_value;
    logic [TAG_W-1:0]  r_out_commit_index, n_out_commit_index;
    t_commit_res       r_out_res, n_out_res;

    logic              advance;
    logic              in_accept;
    logic              commit;
    logic              alloc_ok;
    logic [BUFFER_DEPTH-1:0] alu_hit, mem_hit, alloc_hit;
    logic [31:0]       tail_wide, head_wide;
    t_head_entry       head_entry;
    t_commit_res       res;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_alloc_valid  <= i_alloc_valid;
            r_s1_alloc_kind   <= i_alloc_kind;
            r_s1_alloc_dest   <= i_alloc_dest;
            r_s1_alloc_pc     <= i_alloc_pc;
            r_s1_alloc_alt_pc <= i_alloc_alt_pc;
            r_s1_alu_valid    <= i_alu_valid;
            r_s1_alu_tag      <= i_alu_tag;
            r_s1_alu_value    <= i_alu_value;
            r_s1_mem_valid    <= i_mem_valid;
            r_s1_mem_tag      <= i_mem_tag;
            r_s1_mem_value    <= i_mem_value;
        end
    end

    assign commit   = (r_count != '0) && r_done[r_head];
    assign alloc_ok = r_s1_alloc_valid && (r_count < CW'(BUFFER_DEPTH));

    always_comb begin
        head_entry.valid  = commit && !r_flush;
        head_entry.kind   = r_kind[r_head];
        head_entry.value  = r_value[r_head];
        head_entry.pc     = r_pc[r_head];
        head_entry.alt_pc = r_alt_pc[r_head];
    end

    rbc_branch_check u_branch_check (
        .i_head (head_entry),
        .o_res  (res)
    );

    always_comb begin
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
            // tags at or above the depth match no entry
            alu_hit[i]   = r_s1_alu_valid && (32'(r_s1_alu_tag) == 32'(i));
            mem_hit[i]   = r_s1_mem_valid && (32'(r_s1_mem_tag) == 32'(i));
            alloc_hit[i] = alloc_ok && (r_tail == IW'(i));
        end
    end

    always_comb begin
        tail_wide = 32'(r_tail);
        head_wide = 32'(r_head);

        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_flush = r_flush;
        n_done  = r_done;

        n_out_alloc_index    = '0;
        n_out_alloc_accepted = 1'b0;
        n_out_commit_valid   = 1'b0;
        n_out_commit_kind    = '0;
        n_out_commit_dest    = '0;
        n_out_commit_value   = '0;
        n_out_commit_index   = '0;
        n_out_res            = res;

        if (r_flush) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
            n_flush = 1'b0;
            n_done  = '0;
        end else begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                if (alloc_hit[i]) begin
                    n_done[i] = 1'b0;
                end else if (alu_hit[i] || mem_hit[i]) begin
                    n_done[i] = 1'b1;
                end
            end
            if (commit) begin
                n_out_commit_valid = 1'b1;
                n_out_commit_kind  = r_kind[r_head];
                n_out_commit_dest  = r_dest[r_head];
                n_out_commit_value = r_value[r_head];
                n_out_commit_index = head_wide[TAG_W-1:0];
                n_head  = (r_head == IW'(BUFFER_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_flush = res.mispredict;
            end
            if (alloc_ok) begin
                n_out_alloc_index    = tail_wide[TAG_W-1:0];
                n_out_alloc_accepted = 1'b1;
                n_tail  = (r_tail == IW'(BUFFER_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (commit && !alloc_ok) begin
                n_count = r_count - 1'b1;
            end else if (alloc_ok && !commit) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_flush <= 1'b0;
            r_done  <= '0;
        end else if (advance) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_flush <= n_flush;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !r_flush) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                // memory writeback wins on equal tags
                if (mem_hit[i]) begin
                    r_value[i] <= r_s1_mem_value;
                end else if (alu_hit[i]) begin
                    r_value[i] <= r_s1_alu_value;
                end
                if (alloc_hit[i]) begin
                    r_kind[i]   <= r_s1_alloc_kind;
                    r_dest[i]   <= r_s1_alloc_dest;
                    r_pc[i]     <= r_s1_alloc_pc;
                    r_alt_pc[i] <= r_s1_alloc_alt_pc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_alloc_index    <= n_out_alloc_index;
            r_out_alloc_accepted <= n_out_alloc_accepted;
            r_out_commit_valid   <= n_out_commit_valid;
            r_out_commit_kind    <= n_out_commit_kind;
            r_out_commit_dest    <= n_out_commit_dest;
            r_out_commit_value   <= n_out_commit_value;
            r_out_commit_index   <= n_out_commit_index;
            r_out_res            <= n_out_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_alloc_index    = r_out_alloc_index;
    assign o_alloc_accepted = r_out_alloc_accepted;
    assign o_commit_valid   = r_out_commit_valid;
    assign o_commit_kind    = r_out_commit_kind;
    assign o_commit_dest    = r_out_commit_dest;
    assign o_commit_value   = r_out_commit_value;
    assign o_commit_index   = r_out_commit_index;
    assign o_branch_pc      = r_out_res.branch_pc;
    assign o_branch_taken   = r_out_res.taken;
    assign o_mispredict     = r_out_res.mispredict;
    assign o_redirect_pc    = r_out_res.redirect_pc;
    assign o_exit_request   = r_out_res.exit_req;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_DEPTH))
        else $error("entry count beyond buffer depth");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_flush |=> r_count == '0 && r_done == '0 && !r_flush)
        else $error("flush did not empty the buffer");

    a_mispredict_arms_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res.mispredict |=> r_flush && o_out_valid && o_mispredict)
        else $error("mispredict did not schedule a flush");

    a_mispredict_is_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mispredict |-> o_commit_valid && o_commit_kind == KIND_BRANCH)
        else $error("mispredict without a committed branch");

endmodule

// File: sv/rbc_branch_check.sv
// branch resolution and exit detection for the committing head entry
module rbc_branch_check (
    input  rbc_pkg::t_head_entry i_head,
    output rbc_pkg::t_commit_res o_res
);
    import rbc_pkg::*;

    logic [DATA_W-1:0] pc4;
    logic [DATA_W-1:0] guess;
    logic              br_commit;

    always_comb begin
        pc4       = i_head.pc + BRANCH_STEP;
        // the outcome that mispredicts: taken when the other path is not the fall-through
        guess     = (i_head.alt_pc != pc4) ? 32'd1 : 32'd0;
        br_commit = i_head.valid && (i_head.kind == KIND_BRANCH);

        o_res = '0;
        if (br_commit) begin
            o_res.branch_pc = i_head.pc;
            o_res.taken     = (i_head.value == 32'd1);
            if (i_head.value == guess) begin
                o_res.mispredict  = 1'b1;
                o_res.redirect_pc = i_head.alt_pc;
            end
        end
        o_res.exit_req = i_head.valid && (i_head.kind == KIND_EXIT);
    end

endmodule
